### src/slir_pkg.sv
// Shared types and constants for the sorted list insert/remove block.
package slir_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OUT_CNT_W = 5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_REMOVED   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic                    ins_en;
        logic                    rem_en;
        logic signed [VAL_W-1:0] value;
    } t_req;

    // Reported count is the stored count masked to the field width
    function automatic logic [OUT_CNT_W-1:0] f_out_count(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[OUT_CNT_W-1:0];
    endfunction

endpackage

### src/slir_cell.sv
// One entry of the sorted chain: compare against the request and shift left or right.
module slir_cell
    import slir_pkg::*;
(
    input  logic                    i_clk,
    input  t_req                    i_req,
    input  logic                    i_occ,
    input  logic                    i_left_gt,
    input  logic signed [VAL_W-1:0] i_left_val,
    input  logic signed [VAL_W-1:0] i_right_val,
    output logic signed [VAL_W-1:0] o_val,
    output logic                    o_gt,
    output logic                    o_eq
);

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;
    logic                    w_ge;

    assign o_gt = i_occ && (i_req.value > r_val);
    assign o_eq = i_occ && (i_req.value == r_val);
    assign w_ge = i_occ && (r_val >= i_req.value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_req.ins_en && !o_gt) begin
            // first non-smaller slot takes the new value, cells after it move right
            n_val = i_left_gt ? i_req.value : i_left_val;
        end else if (i_req.rem_en && w_ge) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

### src/sorted_list_insert_remove_core.sv
// Sorted list insert/remove core: top level with request register and cell chain.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a chain of
// cells. Input channel: i_valid/o_ready with i_kind (0 insert, 1 remove) and
// i_value. Output channel: o_valid/i_ready with o_status, o_entry_count and
// o_is_vacant; every request yields exactly one result.
// Timing: a request is registered in the cycle it is accepted; once the
// output register is free, every cell compares in parallel and shifts by one
// place, and the result is loaded into the output register, raising o_valid.
// One request is in flight at a time: a new request is taken only after the
// register-then-update cell step of the previous one is done.
// A new request is accepted while a previous result still waits on i_ready.
// If the receiver stalls, the pending request holds until the output register
// frees up, and o_ready stays low meanwhile.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending
// request or result. Inserting into a full list leaves it unchanged and
// reports status 3; removing an absent value reports status 2.
module sorted_list_insert_remove_core
    import slir_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_kind,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_status,
    output logic [OUT_CNT_W-1:0]    o_entry_count,
    output logic                    o_is_vacant
);

    logic                    r_busy;
    logic                    r_kind;
    logic signed [VAL_W-1:0] r_value;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic [1:0]              r_status;
    logic [1:0]              n_status;
    logic [OUT_CNT_W-1:0]    r_out_count;
    logic                    r_vacant;

    logic                    w_exec;
    logic                    w_full;
    logic                    w_found;
    t_req                    w_req;

    logic [CAPACITY-1:0]     w_occ;
    logic [CAPACITY-1:0]     w_gt;
    logic [CAPACITY-1:0]     w_eq;
    logic signed [VAL_W-1:0] w_val [CAPACITY];

    assign o_ready = !r_busy;
    assign w_exec  = r_busy && (!r_out_valid || i_ready);
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_found = |w_eq;

    assign w_req.value  = r_value;
    assign w_req.ins_en = w_exec && (r_kind == KIND_INSERT) && !w_full;
    assign w_req.rem_en = w_exec && (r_kind == KIND_REMOVE) && w_found;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign w_occ[g] = (32'(g) < 32'(r_count));

            slir_cell u_cell (
                .i_clk       (i_clk),
                .i_req       (w_req),
                .i_occ       (w_occ[g]),
                .i_left_gt   ((g == 0) ? 1'b1 : w_gt[(g == 0) ? 0 : g - 1]),
                .i_left_val  (w_val[(g == 0) ? 0 : g - 1]),
                .i_right_val (w_val[(g == CAPACITY - 1) ? g : g + 1]),
                .o_val       (w_val[g]),
                .o_gt        (w_gt[g]),
                .o_eq        (w_eq[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = ST_NOT_FOUND;
        if (r_kind == KIND_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_INSERTED;
                n_count  = r_count + CNT_W'(1);
            end
        end else if (w_found) begin
            n_status = ST_REMOVED;
            n_count  = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        if (w_exec) begin
            r_status    <= n_status;
            r_out_count <= f_out_count(n_count);
            r_vacant    <= (n_count == '0);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_out_count;
    assign o_is_vacant   = r_vacant;

endmodule

### dv/sorted_list_insert_remove_checker.sv
// Checker for the sorted list core: tracks the table, predicts each reply and compares.
`timescale 1ns / 1ps

module sorted_list_insert_remove_checker
    import slir_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    input  logic                    i_req_ready,
    input  logic                    i_req_kind,
    input  logic signed [VAL_W-1:0] i_req_value,
    input  logic                    i_rsp_valid,
    input  logic                    i_rsp_ready,
    input  logic [1:0]              i_rsp_status,
    input  logic [OUT_CNT_W-1:0]    i_rsp_count,
    input  logic                    i_rsp_vacant,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_full_seen,
    output int                      o_miss_seen
);

    typedef struct packed {
        logic [1:0]           status;
        logic [OUT_CNT_W-1:0] count;
        logic                 vacant;
    } t_reply;

    logic signed [VAL_W-1:0] table_vals [CAPACITY];
    int                      n_stored = 0;
    t_reply                  awaited_replies [$];
    int                      fails = 0;
    int                      checked = 0;
    int                      full_seen = 0;
    int                      miss_seen = 0;

    // Applies one request to the shadow table and returns the reply it should produce
    function automatic t_reply apply_request(input logic kind,
                                             input logic signed [VAL_W-1:0] v);
        t_reply r;
        int     pos;
        pos = 0;
        if (kind == KIND_INSERT) begin
            if (n_stored >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // lands ahead of any equal entries
                while (pos < n_stored && v > table_vals[pos]) pos++;
                for (int i = n_stored; i > pos; i--) table_vals[i] = table_vals[i-1];
                table_vals[pos] = v;
                n_stored++;
                r.status = ST_INSERTED;
            end
        end else begin
            while (pos < n_stored && table_vals[pos] != v) pos++;
            if (pos >= n_stored) begin
                r.status = ST_NOT_FOUND;
            end else begin
                for (int i = pos; i + 1 < n_stored; i++) table_vals[i] = table_vals[i+1];
                n_stored--;
                r.status = ST_REMOVED;
            end
        end
        r.count  = n_stored[OUT_CNT_W-1:0];
        r.vacant = (n_stored == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            n_stored = 0;
            awaited_replies.delete();
        end else begin
            // reply side first: a request accepted on this edge cannot answer on it
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_replies.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected reply status=%0d count=%0d vacant=%0d",
                             $time, i_rsp_status, i_rsp_count, i_rsp_vacant);
                end else begin
                    want = awaited_replies.pop_front();
                    checked++;
                    if (i_rsp_status == ST_FULL) full_seen++;
                    if (i_rsp_status == ST_NOT_FOUND) miss_seen++;
                    if (i_rsp_status !== want.status) begin
                        fails++;
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.status, i_rsp_status);
                    end
                    if (i_rsp_count !== want.count) begin
                        fails++;
                        $display("%0t: entry_count mismatch expected %0d actual %0d",
                                 $time, want.count, i_rsp_count);
                    end
                    if (i_rsp_vacant !== want.vacant) begin
                        fails++;
                        $display("%0t: is_vacant mismatch expected %0d actual %0d",
                                 $time, want.vacant, i_rsp_vacant);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                awaited_replies.push_back(apply_request(i_req_kind, i_req_value));
            end
        end
        o_pending    <= awaited_replies.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_full_seen  <= full_seen;
        o_miss_seen  <= miss_seen;
    end

endmodule

### dv/tb_sorted_list_insert_remove_core.sv
// Testbench top for the sorted list core: clock, reset, request and reply traffic, verdict.
`timescale 1ns / 1ps

module tb_sorted_list_insert_remove_core
    import slir_pkg::*;
();

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    i_kind = KIND_INSERT;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    i_ready = 1'b0;
    logic                    o_ready;
    logic                    o_valid;
    logic [1:0]              o_status;
    logic [OUT_CNT_W-1:0]    o_entry_count;
    logic                    o_is_vacant;

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int miss_seen;

    bit calm = 1'b0;
    int n_ins = 0;
    int n_rem = 0;
    // insert share per block of random traffic: swings between filling and draining
    int ins_pct_by_blk [10] = '{85, 60, 20, 95, 50, 10, 75, 35, 90, 15};

    always #5 i_clk = ~i_clk;

    sorted_list_insert_remove_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_vacant   (o_is_vacant)
    );

    sorted_list_insert_remove_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_req_kind   (i_kind),
        .i_req_value  (i_value),
        .i_rsp_valid  (o_valid),
        .i_rsp_ready  (i_ready),
        .i_rsp_status (o_status),
        .i_rsp_count  (o_entry_count),
        .i_rsp_vacant (o_is_vacant),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_seen  (full_seen),
        .o_miss_seen  (miss_seen)
    );

    // Presents one request and returns at the edge where it is taken
    task automatic send_request(input logic kind, input logic signed [VAL_W-1:0] v);
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= v;
        if (kind == KIND_INSERT) n_ins++;
        else n_rem++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Mostly a narrow pool so removes hit and duplicates pile up
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return 32'($urandom_range(0, 15)) - 32'd8;
        endcase
    endfunction

    // Reply side: random stall bursts, steady once the run calms down
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    initial begin
        int   wait_cnt;
        logic kind;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, duplicates, match positions, full table
        send_request(KIND_REMOVE, 32'sd0);
        maybe_pause();
        send_request(KIND_INSERT, 32'sh7FFF_FFFF);
        send_request(KIND_INSERT, 32'sh8000_0000);
        maybe_pause();
        send_request(KIND_INSERT, 32'sd0);
        send_request(KIND_INSERT, -32'sd1);
        send_request(KIND_INSERT, 32'sd5);
        send_request(KIND_INSERT, 32'sd5);
        maybe_pause();
        send_request(KIND_INSERT, 32'sd5);
        send_request(KIND_REMOVE, 32'sd5);
        send_request(KIND_REMOVE, 32'sh8000_0000);   // match at head
        send_request(KIND_REMOVE, 32'sd0);           // match in second place
        send_request(KIND_REMOVE, 32'sd123);         // absent, table not empty
        maybe_pause();
        for (int i = 0; i < 12; i++) begin
            send_request(KIND_INSERT, 32'sd1000 - 32'(7 * i));
        end
        send_request(KIND_INSERT, 32'sd7);           // table full, dropped
        send_request(KIND_REMOVE, 32'sh7FFF_FFFF);   // match at tail

        for (int blk = 0; blk < 10; blk++) begin
            if (blk == 8) calm = 1'b1;
            for (int k = 0; k < 50; k++) begin
                kind = ($urandom_range(1, 100) <= ins_pct_by_blk[blk]) ? KIND_INSERT
                                                                       : KIND_REMOVE;
                send_request(kind, pick_value());
                maybe_pause();
            end
        end
        i_valid <= 1'b0;

        for (wait_cnt = 0; wait_cnt < 1000 && pending != 0; wait_cnt++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d inserts and %0d removes; %0d replies checked.",
                 n_ins, n_rem, checked);
        $display("Full-table drops seen: %0d, removes of absent values seen: %0d.",
                 full_seen, miss_seen);
        if (pending != 0) $display("%0d replies never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_sorted_list_insert_remove_core: PASS");
        end else begin
            $display("tb_sorted_list_insert_remove_core: FAIL");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("timeout with %0d replies outstanding", pending);
        $display("tb_sorted_list_insert_remove_core: FAIL");
        $finish;
    end

endmodule
